// File: sv/tses_pkg.sv
package tses_pkg;

	localparam longint unsigned SAMPLE_RATE = 48000;

	localparam int NVOICES = 4;
	localparam int VIDX_W = $clog2(NVOICES);
	localparam int PHASE_W = 32;
	localparam int LEVEL_W = 16;
	localparam int REM_W = 16;
	localparam int SEED_W = 32;

	localparam logic [SEED_W-1:0] SEED_RESET = 32'h0000_8080;
	localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

	// Increment for f Hz, rounded to nearest
	function automatic logic [PHASE_W-1:0] freq_inc(input longint unsigned hz);
		return PHASE_W'(((hz << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE);
	endfunction

	// Voice length in samples for a duration in ms, saturated
	function automatic logic [REM_W-1:0] dur_len(input longint unsigned ms);
		longint unsigned len;
		len = (SAMPLE_RATE * ms) / 1000;
		return (len > 65535) ? {REM_W{1'b1}} : REM_W'(len);
	endfunction

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [PHASE_W-1:0] inc;
		logic [LEVEL_W-1:0] level;
		logic [REM_W-1:0]   rem;
		logic               noise;
	} voice_t;

	localparam logic [LEVEL_W-1:0] LVL_020 = 16'd6554;
	localparam logic [LEVEL_W-1:0] LVL_024 = 16'd7864;
	localparam logic [LEVEL_W-1:0] LVL_016 = 16'd5243;
	localparam logic [LEVEL_W-1:0] LVL_014 = 16'd4588;

	localparam voice_t V_SHOT      = '{'0, freq_inc(700), LVL_020, dur_len(180), 1'b1};
	localparam voice_t V_EXPLODE   = '{'0, freq_inc(90),  LVL_024, dur_len(550), 1'b1};
	localparam voice_t V_INV_HIT   = '{'0, freq_inc(420), LVL_016, dur_len(100), 1'b0};
	localparam voice_t V_BONUS     = '{'0, freq_inc(880), LVL_014, dur_len(250), 1'b0};
	localparam voice_t V_UFO_HIT   = '{'0, freq_inc(160), LVL_024, dur_len(400), 1'b1};
	localparam voice_t V_MARCH [4] = '{
		'{'0, freq_inc(85),  LVL_020, dur_len(70), 1'b0},
		'{'0, freq_inc(107), LVL_020, dur_len(70), 1'b0},
		'{'0, freq_inc(129), LVL_020, dur_len(70), 1'b0},
		'{'0, freq_inc(151), LVL_020, dur_len(70), 1'b0}
	};

	localparam logic [PHASE_W-1:0] TONE_INC = freq_inc(110);
	localparam logic [PHASE_W-1:0] TONE_DUTY = 32'd1932735283;

	// weight = floor(rem * 2^15 / SAMPLE_RATE) + WEIGHT_BIAS via reciprocal plus one correction
	localparam int DIV_SHIFT = 16;
	localparam longint unsigned RECIP = (64'd1 << (15 + DIV_SHIFT)) / SAMPLE_RATE;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'(RECIP);
	localparam int SR_W = $clog2(SAMPLE_RATE + 1);
	localparam logic [SR_W-1:0] SR_VAL = SR_W'(SAMPLE_RATE);
	localparam int PDIV_W = REM_W + RECIP_W;
	localparam int PBACK_W = RECIP_W + SR_W;
	localparam int CMP_W = (PBACK_W > REM_W + 15) ? PBACK_W : REM_W + 15;
	localparam int WT_W = RECIP_W + 1;
	localparam logic [WT_W-1:0] WEIGHT_BIAS = WT_W'(4915);
	localparam int PMAG_W = LEVEL_W + WT_W;
	localparam int MAG_W = PMAG_W + 1 - 15;
	localparam int ACC_W = MAG_W + 4;

	localparam int SAMPLE_W = 16;
	localparam logic signed [ACC_W-1:0] TONE_AMP = ACC_W'(3277);
	localparam logic signed [ACC_W-1:0] MIX_LIMIT = ACC_W'(26214);

	typedef struct packed {
		logic              port_load;
		logic              tone_step;
		logic              voice_gen;
		logic              voice_div;
		logic              voice_mul;
		logic              voice_acc;
		logic              out_load;
		logic [VIDX_W-1:0] vidx;
	} cmd_t;

	typedef struct packed {
		logic rem_zero;
	} status_t;

endpackage

// File: sv/triggered_sound_effect_synth.sv
// Triggered sound-effect synthesizer: one gated 110 Hz tone plus four one-shot
// voices (square or LCG noise) with a linearly decaying amplitude weight.
// Input channel (in_valid/in_ready): req_type 0 is a port write carrying
// port3_value and port5_value; rising bits start voices, port3 bit 0 gates
// the tone. A port write is absorbed in the accepting cycle and gives no
// result. req_type 1 is a tick that yields one saturated Q1.15 sample.
// Output channel (out_valid/out_ready): one transaction per tick.
// Steps of a tick: tone step, then per active voice generate, divide, multiply
// and accumulate (one shared reciprocal divider and level multiplier, stepped
// per voice), then a finish step that loads the output register; a silent
// voice takes only its generate step. in_ready is high only while the
// sequencer is idle, so items are taken one at a time.
// The output register frees the sequencer: the next item is accepted while a
// sample waits. If the receiver stalls, a following tick completes its math
// and holds in its final step until the output register empties.
// Reset (arst_n low) silences all voices, disables the tone, clears phases
// and sets the noise seed to 0x8080; no pending output remains.
module triggered_sound_effect_synth (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [7:0]                          port3_value,
	input  logic [7:0]                          port5_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tses_pkg::SAMPLE_W-1:0] sample
);

	tses_pkg::cmd_t    cmd;
	tses_pkg::status_t status;

	tses_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	tses_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.port3_value (port3_value),
		.port5_value (port5_value),
		.sample      (sample)
	);

endmodule

// File: sv/tses_datapath.sv
module tses_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tses_pkg::cmd_t                      cmd,
	output tses_pkg::status_t                   status,
	input  logic [7:0]                          port3_value,
	input  logic [7:0]                          port5_value,
	output logic signed [tses_pkg::SAMPLE_W-1:0] sample
);

	tses_pkg::voice_t voice_q [tses_pkg::NVOICES];
	logic [tses_pkg::PHASE_W-1:0] tone_phase_q;
	logic                         tone_en_q;
	logic [tses_pkg::SEED_W-1:0]  seed_q;
	logic [7:0]                   prev3_q;
	logic [7:0]                   prev5_q;

	logic [tses_pkg::PDIV_W-1:0]  prod_div_q;
	logic [tses_pkg::RECIP_W-1:0] quot_q;
	logic [tses_pkg::PBACK_W-1:0] prod_back_q;
	logic [tses_pkg::PMAG_W-1:0]  prod_mag_q;
	logic                         pos_q;
	logic signed [tses_pkg::ACC_W-1:0]    acc_q;
	logic signed [tses_pkg::SAMPLE_W-1:0] sample_q;

	tses_pkg::voice_t             cur;
	logic [7:0]                   rise3, rise5;
	logic [tses_pkg::SEED_W-1:0]  seed_next;
	logic [tses_pkg::PHASE_W-1:0] phase_next;
	logic [tses_pkg::PHASE_W-1:0] tone_next;
	logic [tses_pkg::RECIP_W-1:0] quot_c;
	logic [tses_pkg::CMP_W-1:0]   resid;
	logic [tses_pkg::WT_W-1:0]    weight;
	logic [tses_pkg::PMAG_W:0]    mag_round;
	logic [tses_pkg::MAG_W-1:0]   mag;
	logic signed [tses_pkg::ACC_W-1:0] mag_s;

	always_comb begin
		cur = voice_q[cmd.vidx];
		rise3 = port3_value & ~prev3_q;
		rise5 = port5_value & ~prev5_q;
		seed_next = seed_q * tses_pkg::LCG_MUL + tses_pkg::LCG_ADD;
		phase_next = cur.phase + cur.inc;
		tone_next = tone_phase_q + tses_pkg::TONE_INC;
		quot_c = prod_div_q[tses_pkg::DIV_SHIFT +: tses_pkg::RECIP_W];
		// remainder of rem*2^15 - q*rate; one step up when it reaches the rate
		resid = tses_pkg::CMP_W'({cur.rem, 15'd0}) - tses_pkg::CMP_W'(prod_back_q);
		weight = tses_pkg::WT_W'(quot_q) + tses_pkg::WEIGHT_BIAS
			+ tses_pkg::WT_W'(resid >= tses_pkg::CMP_W'(tses_pkg::SR_VAL));
		mag_round = (tses_pkg::PMAG_W + 1)'(prod_mag_q) + (tses_pkg::PMAG_W + 1)'(16384);
		mag = mag_round[tses_pkg::PMAG_W:15];
		mag_s = signed'(tses_pkg::ACC_W'(mag));
	end

	assign status.rem_zero = (cur.rem == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < tses_pkg::NVOICES; v++) begin
				voice_q[v] <= '0;
			end
			tone_phase_q <= '0;
			tone_en_q <= 1'b0;
			seed_q <= tses_pkg::SEED_RESET;
			prev3_q <= '0;
			prev5_q <= '0;
		end else begin
			if (cmd.port_load) begin
				// when triggers rise together on one voice, the first one listed below wins
				tone_en_q <= port3_value[0];
				if (rise3[1]) voice_q[0] <= tses_pkg::V_SHOT;
				if (rise5[4]) begin
					voice_q[1] <= tses_pkg::V_UFO_HIT;
				end else if (rise3[2]) begin
					voice_q[1] <= tses_pkg::V_EXPLODE;
				end
				if (rise3[4]) begin
					voice_q[2] <= tses_pkg::V_BONUS;
				end else if (rise3[3]) begin
					voice_q[2] <= tses_pkg::V_INV_HIT;
				end
				if (rise5[3]) begin
					voice_q[3] <= tses_pkg::V_MARCH[3];
				end else if (rise5[2]) begin
					voice_q[3] <= tses_pkg::V_MARCH[2];
				end else if (rise5[1]) begin
					voice_q[3] <= tses_pkg::V_MARCH[1];
				end else if (rise5[0]) begin
					voice_q[3] <= tses_pkg::V_MARCH[0];
				end
				prev3_q <= port3_value;
				prev5_q <= port5_value;
			end
			if (cmd.tone_step && tone_en_q) begin
				tone_phase_q <= tone_next;
			end
			if (cmd.voice_gen) begin
				if (cur.noise) begin
					seed_q <= seed_next;
				end else begin
					voice_q[cmd.vidx].phase <= phase_next;
				end
			end
			if (cmd.voice_acc) begin
				voice_q[cmd.vidx].rem <= cur.rem - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tone_step) begin
			if (!tone_en_q) begin
				acc_q <= '0;
			end else begin
				acc_q <= (tone_next < tses_pkg::TONE_DUTY) ? tses_pkg::TONE_AMP
					: -tses_pkg::TONE_AMP;
			end
		end
		if (cmd.voice_gen) begin
			pos_q <= cur.noise ? seed_next[tses_pkg::SEED_W-1] : !phase_next[tses_pkg::PHASE_W-1];
			prod_div_q <= tses_pkg::PDIV_W'(cur.rem) * tses_pkg::PDIV_W'(tses_pkg::RECIP_VAL);
		end
		if (cmd.voice_div) begin
			quot_q <= quot_c;
			prod_back_q <= tses_pkg::PBACK_W'(quot_c) * tses_pkg::PBACK_W'(tses_pkg::SR_VAL);
		end
		if (cmd.voice_mul) begin
			prod_mag_q <= tses_pkg::PMAG_W'(cur.level) * tses_pkg::PMAG_W'(weight);
		end
		if (cmd.voice_acc) begin
			acc_q <= pos_q ? acc_q + mag_s : acc_q - mag_s;
		end
		if (cmd.out_load) begin
			priority if (acc_q > tses_pkg::MIX_LIMIT) begin
				sample_q <= tses_pkg::SAMPLE_W'(tses_pkg::MIX_LIMIT);
			end else if (acc_q < -tses_pkg::MIX_LIMIT) begin
				sample_q <= tses_pkg::SAMPLE_W'(-tses_pkg::MIX_LIMIT);
			end else begin
				sample_q <= tses_pkg::SAMPLE_W'(acc_q);
			end
		end
	end

	assign sample = sample_q;

endmodule

// File: sv/tses_ctrl.sv
module tses_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	output logic              out_valid,
	input  logic              out_ready,
	output tses_pkg::cmd_t    cmd,
	input  tses_pkg::status_t status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TONE,
		S_VGEN,
		S_VDIV,
		S_VMUL,
		S_VACC,
		S_FINISH
	} state_t;

	localparam logic [tses_pkg::VIDX_W-1:0] LAST_VOICE = tses_pkg::VIDX_W'(tses_pkg::NVOICES - 1);

	state_t state_q;
	logic [tses_pkg::VIDX_W-1:0] vidx_q;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.vidx = vidx_q;
		cmd.port_load = accept && !req_type;
		cmd.tone_step = (state_q == S_TONE);
		cmd.voice_gen = (state_q == S_VGEN) && !status.rem_zero;
		cmd.voice_div = (state_q == S_VDIV);
		cmd.voice_mul = (state_q == S_VMUL);
		cmd.voice_acc = (state_q == S_VACC);
		cmd.out_load = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vidx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && req_type) state_q <= S_TONE;
				end
				S_TONE: begin
					vidx_q <= '0;
					state_q <= S_VGEN;
				end
				S_VGEN: begin
					// silent voices are skipped
					if (!status.rem_zero) begin
						state_q <= S_VDIV;
					end else if (vidx_q == LAST_VOICE) begin
						state_q <= S_FINISH;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				S_VDIV: state_q <= S_VMUL;
				S_VMUL: state_q <= S_VACC;
				S_VACC: begin
					if (vidx_q == LAST_VOICE) begin
						state_q <= S_FINISH;
					end else begin
						vidx_q <= vidx_q + 1'b1;
						state_q <= S_VGEN;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && out_valid_q && !out_ready |=> (state_q == S_FINISH))
		else $error("result overwritten while output stalled");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type |=> (state_q == S_TONE))
		else $error("tick transaction did not start tone step");

	a_voice_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VACC) && (vidx_q != LAST_VOICE) |=>
		(state_q == S_VGEN) && ((vidx_q - $past(vidx_q)) == tses_pkg::VIDX_W'(1)))
		else $error("voice index did not advance by one");

	a_active_voice: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VGEN) && !status.rem_zero |=> (state_q == S_VDIV))
		else $error("active voice not processed");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.voice_acc |-> !in_ready && !cmd.port_load)
		else $error("port update during sample computation");

endmodule

// File: tb/triggered_sound_effect_synth_tb.sv
module triggered_sound_effect_synth_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {REQ_PORT = 1'b0, REQ_TICK = 1'b1} req_kind_t;

	localparam int VOICE_SHOT  = 0;
	localparam int VOICE_BOOM  = 1;
	localparam int VOICE_HIT   = 2;
	localparam int VOICE_MARCH = 3;

	localparam longint unsigned RATE = tses_pkg::SAMPLE_RATE;
	localparam logic [31:0] DUTY_POINT = 32'd1932735283;
	localparam int TONE_LEVEL = 3277;
	localparam int CLIP = 26214;
	localparam int RANDOM_ITEMS = 1826;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic               kind;
		logic [7:0]         p3;
		logic [7:0]         p5;
		logic               typed;
		logic signed [15:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic [7:0] port3_value = 8'h00;
	logic [7:0] port5_value = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [tses_pkg::SAMPLE_W-1:0] sample;

	// predictor state
	logic [31:0] tone_ph;
	logic [31:0] v_ph[4];
	logic [31:0] v_step[4];
	logic [15:0] v_lvl[4];
	logic [15:0] v_left[4];
	logic        v_noise[4];
	logic [31:0] lcg;
	logic [7:0]  last_p3, last_p5;
	logic        tone_on;

	logic signed [15:0] samples_due[$];
	logic signed [15:0] due_sample;
	int n_fail = 0;
	int n_taken = 0;
	bit quiet = 1'b0;

	triggered_sound_effect_synth u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.port3_value(port3_value),
		.port5_value(port5_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] hz_to_step(input longint unsigned hz);
		return 32'(((hz << 32) + RATE / 2) / RATE);
	endfunction

	function automatic void arm_voice(input int idx, input longint unsigned hz,
			input logic [15:0] lvl, input longint unsigned ms, input logic noisy);
		longint unsigned len;
		len = (RATE * ms) / 1000;
		if (len > 65535)
			len = 65535;
		v_ph[idx] = '0;
		v_step[idx] = hz_to_step(hz);
		v_lvl[idx] = lvl;
		v_left[idx] = 16'(len);
		v_noise[idx] = noisy;
	endfunction

	function automatic void latch_ports(input logic [7:0] p3, input logic [7:0] p5);
		logic [7:0] up3, up5;
		up3 = p3 & ~last_p3;
		up5 = p5 & ~last_p5;
		tone_on = p3[0];
		// later triggers overwrite earlier ones on a shared voice
		if (up3[1]) arm_voice(VOICE_SHOT, 700, 16'd6554, 180, 1'b1);
		if (up3[2]) arm_voice(VOICE_BOOM, 90, 16'd7864, 550, 1'b1);
		if (up3[3]) arm_voice(VOICE_HIT, 420, 16'd5243, 100, 1'b0);
		if (up3[4]) arm_voice(VOICE_HIT, 880, 16'd4588, 250, 1'b0);
		for (int b = 0; b < 4; b++)
			if (up5[b]) arm_voice(VOICE_MARCH, 85 + 22 * b, 16'd6554, 70, 1'b0);
		if (up5[4]) arm_voice(VOICE_BOOM, 160, 16'd7864, 400, 1'b1);
		last_p3 = p3;
		last_p5 = p5;
	endfunction

	function automatic logic signed [15:0] mix_sample();
		int acc;
		logic pos;
		longint unsigned wt, mag;
		acc = 0;
		if (tone_on) begin
			tone_ph = tone_ph + hz_to_step(110);
			acc += (tone_ph < DUTY_POINT) ? TONE_LEVEL : -TONE_LEVEL;
		end
		for (int v = 0; v < 4; v++) begin
			if (v_left[v] != 16'd0) begin
				if (v_noise[v]) begin
					lcg = lcg * 32'd1664525 + 32'd1013904223;
					pos = lcg[31];
				end else begin
					v_ph[v] = v_ph[v] + v_step[v];
					pos = ~v_ph[v][31];
				end
				wt = ((longint'(v_left[v]) << 15) / RATE) + 4915;
				mag = (longint'(v_lvl[v]) * wt + 16384) >> 15;
				acc += pos ? int'(mag) : -int'(mag);
				v_left[v] = v_left[v] - 16'd1;
			end
		end
		if (acc > CLIP) acc = CLIP;
		if (acc < -CLIP) acc = -CLIP;
		return 16'(acc);
	endfunction

	// hold valid until the transaction goes through, then update the predictor
	task automatic offer(input req_kind_t kind, input logic [7:0] p3, input logic [7:0] p5,
			input logic typed, input logic signed [15:0] want);
		logic signed [15:0] predicted;
		in_valid <= 1'b1;
		req_type <= kind;
		port3_value <= p3;
		port5_value <= p5;
		do @(posedge clk); while (!in_ready);
		n_taken++;
		if (kind == REQ_TICK) begin
			predicted = mix_sample();
			samples_due.push_back(typed ? want : predicted);
		end else begin
			latch_ports(p3, p5);
		end
	endtask

	task automatic random_item();
		req_kind_t kind;
		logic [7:0] p3, p5;
		int k;
		kind = ($urandom_range(0, 9) < 7) ? REQ_TICK : REQ_PORT;
		p3 = 8'($urandom);
		p5 = 8'($urandom);
		if (kind == REQ_PORT) begin
			case ($urandom_range(0, 2))
				0: begin
				end
				1: begin
					// release everything, keep the tone gate random
					p3 = {7'd0, p3[0]};
					p5 = 8'h00;
				end
				default: begin
					k = $urandom_range(0, 8);
					if (k < 4) begin
						p3 = 8'(1 << (k + 1)) | {7'd0, p3[0]};
						p5 = 8'h00;
					end else begin
						p3 = {7'd0, p3[0]};
						p5 = 8'(1 << (k - 4));
					end
				end
			endcase
		end
		offer(kind, p3, p5, 1'b0, 16'sd0);
	endtask

	initial begin
		stim_row_t rows[$];
		tone_ph = '0;
		for (int v = 0; v < 4; v++) begin
			v_ph[v] = '0;
			v_step[v] = '0;
			v_lvl[v] = '0;
			v_left[v] = '0;
			v_noise[v] = 1'b0;
		end
		lcg = 32'h0000_8080;
		last_p3 = '0;
		last_p5 = '0;
		tone_on = 1'b0;

		rows = '{
			'{REQ_TICK, 8'h00, 8'h00, 1'b1, 16'sd0},
			'{REQ_PORT, 8'h01, 8'h00, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b1, 16'sd3277},
			'{REQ_TICK, 8'h00, 8'h00, 1'b1, 16'sd3277},
			'{REQ_PORT, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_TICK, 8'hFF, 8'hFF, 1'b1, 16'sd0},
			'{REQ_PORT, 8'h02, 8'h00, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_PORT, 8'h04, 8'h00, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_PORT, 8'h08, 8'h01, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_PORT, 8'h18, 8'h02, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_PORT, 8'h00, 8'h10, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_PORT, 8'hFF, 8'hFF, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_PORT, 8'hFF, 8'hFF, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h55, 8'hAA, 1'b0, 16'sd0},
			'{REQ_PORT, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_PORT, 8'hE0, 8'hE0, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b0, 16'sd0},
			'{REQ_TICK, 8'h00, 8'h00, 1'b0, 16'sd0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			offer(req_kind_t'(rows[i].kind), rows[i].p3, rows[i].p5, rows[i].typed,
				rows[i].want);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= RANDOM_ITEMS - 150) || (i >= 900 && i < 1050);
			if (i == 1200) begin
				// drain completely before going on
				in_valid <= 1'b0;
				do @(posedge clk); while (samples_due.size() != 0);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			random_item();
		end
		in_valid <= 1'b0;

		while (samples_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stall bursts plus one long hold-off to back the block up
	initial begin
		int hold_left;
		bit long_done;
		hold_left = 0;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0)
				hold_left--;
			else if (!long_done && n_taken >= 500) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD;
			end else if (!quiet && $urandom_range(0, 7) == 0)
				hold_left = $urandom_range(1, 12);
			out_ready <= (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (samples_due.size() == 0) begin
				$error("sample: no transaction expected, got %0d", sample);
				n_fail++;
			end else begin
				due_sample = samples_due.pop_front();
				if (sample !== due_sample) begin
					$error("sample: expected %0d, got %0d", due_sample, sample);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
